/* design/smc_pkg.sv */
// smc_pkg: shared constants for the SQL parameter marker counter.
// Counter width, scan mode codes and character codes.
// No dependencies.
package smc_pkg;

  localparam int COUNT_BITS = 16;
  localparam int OUT_BITS   = 16;
  localparam int MODE_BITS  = 4;

  typedef logic [MODE_BITS-1:0]  mode_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam mode_t MODE_NORMAL   = 4'd0;
  localparam mode_t MODE_DASH     = 4'd1;
  localparam mode_t MODE_SLASH    = 4'd2;
  localparam mode_t MODE_LINE     = 4'd3;
  localparam mode_t MODE_BLOCK    = 4'd4;
  localparam mode_t MODE_BSTAR    = 4'd5;
  localparam mode_t MODE_SQ       = 4'd6;
  localparam mode_t MODE_SQ_QUOTE = 4'd7;
  localparam mode_t MODE_SQ_ESC   = 4'd8;
  localparam mode_t MODE_DQ       = 4'd9;
  localparam mode_t MODE_DQ_QUOTE = 4'd10;
  localparam mode_t MODE_DQ_ESC   = 4'd11;

  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

endpackage

/* design/sql_marker_counter_unit.sv */
// sql_marker_counter_unit: counts '?' markers in a byte stream of SQL text,
// skipping comments and quoted strings. Depends on smc_pkg.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------
//  in      | in_valid  | in_stall  | char_byte, last_char, empty_stmt
//  out     | out_valid | out_stall | marker_count, was_empty
//
// One byte per cycle while in_stall is low; scan mode and count update in the
// cycle of the transfer, and the result lands in the output register on the next edge.
// A result that meets a held output waits in a skid register; in_stall is
// that register's valid flag, so it never follows out_stall in the same cycle.
// rst (synchronous) returns the scanner to plain text with a zero count.
module sql_marker_counter_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  char_byte,
  input  logic                        last_char,
  input  logic                        empty_stmt,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [smc_pkg::OUT_BITS-1:0] marker_count,
  output logic                        was_empty
);

  localparam int WIDE = smc_pkg::COUNT_BITS + smc_pkg::OUT_BITS;
  localparam smc_pkg::count_t COUNT_MAX = {smc_pkg::COUNT_BITS{1'b1}};

  smc_pkg::mode_t  scan_mode, scan_mode_next;
  smc_pkg::count_t running_count, running_count_next;
  smc_pkg::count_t count_scanned;
  logic            in_xfer, has_result, marker_hit, out_load;
  logic [smc_pkg::OUT_BITS-1:0] count_out, result_count;
  logic            skid_valid, skid_empty;
  logic [smc_pkg::OUT_BITS-1:0] skid_count;

  function automatic smc_pkg::mode_t plain_next(input logic [7:0] c);
    smc_pkg::mode_t m;
    case (c)
      smc_pkg::CH_DASH:   m = smc_pkg::MODE_DASH;
      smc_pkg::CH_SLASH:  m = smc_pkg::MODE_SLASH;
      smc_pkg::CH_SQUOTE: m = smc_pkg::MODE_SQ;
      smc_pkg::CH_DQUOTE: m = smc_pkg::MODE_DQ;
      default:            m = smc_pkg::MODE_NORMAL;
    endcase
    return m;
  endfunction

  function automatic smc_pkg::mode_t mode_step(input smc_pkg::mode_t mode,
                                               input logic [7:0] c);
    smc_pkg::mode_t m;
    case (mode)
      smc_pkg::MODE_DASH:
        m = (c == smc_pkg::CH_DASH) ? smc_pkg::MODE_LINE : plain_next(c);
      smc_pkg::MODE_SLASH: begin
        if (c == smc_pkg::CH_STAR)       m = smc_pkg::MODE_BLOCK;
        else if (c == smc_pkg::CH_SLASH) m = smc_pkg::MODE_LINE;
        else                             m = plain_next(c);
      end
      smc_pkg::MODE_LINE:
        m = (c == smc_pkg::CH_NL) ? smc_pkg::MODE_NORMAL : smc_pkg::MODE_LINE;
      smc_pkg::MODE_BLOCK:
        m = (c == smc_pkg::CH_STAR) ? smc_pkg::MODE_BSTAR : smc_pkg::MODE_BLOCK;
      smc_pkg::MODE_BSTAR: begin
        if (c == smc_pkg::CH_SLASH)     m = smc_pkg::MODE_NORMAL;
        else if (c == smc_pkg::CH_STAR) m = smc_pkg::MODE_BSTAR;
        else                            m = smc_pkg::MODE_BLOCK;
      end
      smc_pkg::MODE_SQ: begin
        if (c == smc_pkg::CH_SQUOTE)      m = smc_pkg::MODE_SQ_QUOTE;
        else if (c == smc_pkg::CH_BSLASH) m = smc_pkg::MODE_SQ_ESC;
        else                              m = smc_pkg::MODE_SQ;
      end
      smc_pkg::MODE_SQ_QUOTE:
        m = (c == smc_pkg::CH_SQUOTE) ? smc_pkg::MODE_SQ : plain_next(c);
      smc_pkg::MODE_SQ_ESC:
        m = smc_pkg::MODE_SQ;
      smc_pkg::MODE_DQ: begin
        if (c == smc_pkg::CH_DQUOTE)      m = smc_pkg::MODE_DQ_QUOTE;
        else if (c == smc_pkg::CH_BSLASH) m = smc_pkg::MODE_DQ_ESC;
        else                              m = smc_pkg::MODE_DQ;
      end
      smc_pkg::MODE_DQ_QUOTE:
        m = (c == smc_pkg::CH_DQUOTE) ? smc_pkg::MODE_DQ : plain_next(c);
      smc_pkg::MODE_DQ_ESC:
        m = smc_pkg::MODE_DQ;
      default:
        m = plain_next(c);
    endcase
    return m;
  endfunction

  // a '?' counts in every mode that falls back to plain text on it
  function automatic logic plain_fallback(input smc_pkg::mode_t mode);
    logic p;
    case (mode)
      smc_pkg::MODE_LINE, smc_pkg::MODE_BLOCK, smc_pkg::MODE_BSTAR,
      smc_pkg::MODE_SQ, smc_pkg::MODE_SQ_ESC,
      smc_pkg::MODE_DQ, smc_pkg::MODE_DQ_ESC: p = 1'b0;
      default:                                p = 1'b1;
    endcase
    return p;
  endfunction

  assign in_stall     = skid_valid;
  assign in_xfer      = in_valid && !in_stall;
  assign has_result   = empty_stmt || last_char;
  assign marker_hit   = (char_byte == smc_pkg::CH_QMARK) && plain_fallback(scan_mode);
  assign out_load     = !out_valid || !out_stall;
  assign result_count = empty_stmt ? '0 : count_out;

  always_comb begin
    count_scanned = running_count;
    if (marker_hit && running_count != COUNT_MAX) begin
      count_scanned = running_count + smc_pkg::COUNT_BITS'(1);
    end
    if (WIDE'(count_scanned) > WIDE'({smc_pkg::OUT_BITS{1'b1}})) begin
      count_out = {smc_pkg::OUT_BITS{1'b1}};
    end else begin
      count_out = smc_pkg::OUT_BITS'(count_scanned);
    end

    scan_mode_next     = scan_mode;
    running_count_next = running_count;
    if (in_xfer) begin
      if (has_result) begin
        scan_mode_next     = smc_pkg::MODE_NORMAL;
        running_count_next = '0;
      end else begin
        scan_mode_next     = mode_step(scan_mode, char_byte);
        running_count_next = count_scanned;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= smc_pkg::MODE_NORMAL;
      running_count <= '0;
      out_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      scan_mode     <= scan_mode_next;
      running_count <= running_count_next;
      if (out_load) begin
        out_valid  <= skid_valid || (in_xfer && has_result);
        skid_valid <= 1'b0;
      end else if (in_xfer && has_result) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // skid entry drains first; no input transfer while it is full
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid) begin
        marker_count <= skid_count;
        was_empty    <= skid_empty;
      end else if (in_xfer && has_result) begin
        marker_count <= result_count;
        was_empty    <= empty_stmt;
      end
    end else if (in_xfer && has_result) begin
      skid_count <= result_count;
      skid_empty <= empty_stmt;
    end
  end

endmodule

/* design/smc_checker.sv */
// smc_checker: port-level assertions for sql_marker_counter_unit.
// Bound to sql_marker_counter_unit below; uses smc_pkg for the count width.
module smc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         last_char,
  input logic                         empty_stmt,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [smc_pkg::OUT_BITS-1:0] marker_count,
  input logic                         was_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(marker_count) && $stable(was_empty))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_empty |-> marker_count == '0)
    else $error("empty statement with nonzero count");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && empty_stmt && !(out_valid && out_stall)
    |=> out_valid && was_empty)
    else $error("empty statement gave no empty result");

  a_last_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_char && !empty_stmt && !(out_valid && out_stall)
    |=> out_valid && !was_empty)
    else $error("last byte gave no count result");

  a_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !last_char && !empty_stmt && !(out_valid && out_stall)
    |=> !out_valid)
    else $error("result without a last byte");

endmodule

bind sql_marker_counter_unit smc_checker u_smc_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for sql_marker_counter_unit, built on smc_pkg.
// Feeds SQL byte streams, predicts the marker count per statement, checks each result.
module tb;

  typedef logic [smc_pkg::OUT_BITS-1:0] out_count_t;

  typedef struct {
    out_count_t count;
    logic       empty;
  } stmt_result_t;

  localparam int RANDOM_ITEMS = 1750;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_byte = 8'h00;
  logic       last_char = 1'b0;
  logic       empty_stmt = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_count_t marker_count;
  logic       was_empty;

  // predictor state
  smc_pkg::mode_t  scan_mode;
  smc_pkg::count_t marker_tally;
  stmt_result_t    pending_results[$];

  int  errors = 0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  bit  send_gaps = 1'b0;
  bit  recv_gaps = 1'b0;

  sql_marker_counter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_byte    (char_byte),
    .last_char    (last_char),
    .empty_stmt   (empty_stmt),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .marker_count (marker_count),
    .was_empty    (was_empty)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // byte seen in plain text
  function automatic smc_pkg::mode_t plain_next(input logic [7:0] c, output logic hit);
    hit = 1'b0;
    case (c)
      smc_pkg::CH_QMARK: begin
        hit = 1'b1;
        return smc_pkg::MODE_NORMAL;
      end
      smc_pkg::CH_DASH:   return smc_pkg::MODE_DASH;
      smc_pkg::CH_SLASH:  return smc_pkg::MODE_SLASH;
      smc_pkg::CH_SQUOTE: return smc_pkg::MODE_SQ;
      smc_pkg::CH_DQUOTE: return smc_pkg::MODE_DQ;
      default:            return smc_pkg::MODE_NORMAL;
    endcase
  endfunction

  function automatic smc_pkg::mode_t scan_next(input smc_pkg::mode_t m,
                                               input logic [7:0] c,
                                               output logic hit);
    hit = 1'b0;
    case (m)
      smc_pkg::MODE_DASH: begin
        if (c == smc_pkg::CH_DASH) return smc_pkg::MODE_LINE;
        return plain_next(c, hit);
      end
      smc_pkg::MODE_SLASH: begin
        if (c == smc_pkg::CH_STAR) return smc_pkg::MODE_BLOCK;
        if (c == smc_pkg::CH_SLASH) return smc_pkg::MODE_LINE;
        return plain_next(c, hit);
      end
      smc_pkg::MODE_LINE:
        return (c == smc_pkg::CH_NL) ? smc_pkg::MODE_NORMAL : smc_pkg::MODE_LINE;
      smc_pkg::MODE_BLOCK:
        return (c == smc_pkg::CH_STAR) ? smc_pkg::MODE_BSTAR : smc_pkg::MODE_BLOCK;
      smc_pkg::MODE_BSTAR: begin
        if (c == smc_pkg::CH_SLASH) return smc_pkg::MODE_NORMAL;
        return (c == smc_pkg::CH_STAR) ? smc_pkg::MODE_BSTAR : smc_pkg::MODE_BLOCK;
      end
      smc_pkg::MODE_SQ: begin
        if (c == smc_pkg::CH_SQUOTE) return smc_pkg::MODE_SQ_QUOTE;
        if (c == smc_pkg::CH_BSLASH) return smc_pkg::MODE_SQ_ESC;
        return smc_pkg::MODE_SQ;
      end
      smc_pkg::MODE_SQ_QUOTE: begin
        if (c == smc_pkg::CH_SQUOTE) return smc_pkg::MODE_SQ;
        return plain_next(c, hit);
      end
      smc_pkg::MODE_SQ_ESC: return smc_pkg::MODE_SQ;
      smc_pkg::MODE_DQ: begin
        if (c == smc_pkg::CH_DQUOTE) return smc_pkg::MODE_DQ_QUOTE;
        if (c == smc_pkg::CH_BSLASH) return smc_pkg::MODE_DQ_ESC;
        return smc_pkg::MODE_DQ;
      end
      smc_pkg::MODE_DQ_QUOTE: begin
        if (c == smc_pkg::CH_DQUOTE) return smc_pkg::MODE_DQ;
        return plain_next(c, hit);
      end
      smc_pkg::MODE_DQ_ESC: return smc_pkg::MODE_DQ;
      default: return plain_next(c, hit);
    endcase
  endfunction

  task automatic predict_count(input logic [7:0] c, input logic lst, input logic emp);
    logic          hit;
    logic [31:0]   wide;
    stmt_result_t  res;
    if (emp) begin
      scan_mode    = smc_pkg::MODE_NORMAL;
      marker_tally = '0;
      res.count    = '0;
      res.empty    = 1'b1;
      pending_results.insert(pending_results.size(), res);
    end else begin
      scan_mode = scan_next(scan_mode, c, hit);
      if (hit && marker_tally != '1) marker_tally = marker_tally + 1'b1;
      if (lst) begin
        wide      = 32'(marker_tally);
        res.count = (wide > 32'hFFFF) ? '1 : out_count_t'(wide);
        res.empty = 1'b0;
        pending_results.insert(pending_results.size(), res);
        scan_mode    = smc_pkg::MODE_NORMAL;
        marker_tally = '0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 50) $display("mismatch: %s got %0d want %0d", what, got, want);
    errors++;
  endtask

  // called and returns at a falling edge; valid stays high into the next call
  task automatic push_char(input logic [7:0] c, input logic lst, input logic emp);
    if (send_gaps) begin
      while ($urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid   <= 1'b1;
    char_byte  <= c;
    last_char  <= lst;
    empty_stmt <= emp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_count(c, lst, emp);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit close_stmt);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], close_stmt && (i == s.len() - 1), 1'b0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 14) return smc_pkg::CH_QMARK;
    if (r < 21) return smc_pkg::CH_DASH;
    if (r < 28) return smc_pkg::CH_SLASH;
    if (r < 34) return smc_pkg::CH_STAR;
    if (r < 39) return smc_pkg::CH_NL;
    if (r < 48) return smc_pkg::CH_SQUOTE;
    if (r < 56) return smc_pkg::CH_DQUOTE;
    if (r < 61) return smc_pkg::CH_BSLASH;
    if (r < 88) return 8'($urandom_range(97, 122));
    return 8'($urandom);
  endfunction

  // empty flag, partial statement dropped, openers cut short, extreme bytes
  task automatic test_statement_ends();
    push_char(8'hFF, 1'b1, 1'b1);
    send_text("x?", 1'b0);
    push_char(8'h00, 1'b0, 1'b1);
    send_text("-", 1'b1);
    send_text("/", 1'b1);
    send_text("'?", 1'b1);
    push_char(8'hFF, 1'b1, 1'b0);
    push_char(8'h00, 1'b0, 1'b0);
    push_char(smc_pkg::CH_QMARK, 1'b1, 1'b0);
    drain();
  endtask

  // doubled quotes and backslash escapes in both quote styles
  task automatic test_quotes();
    send_text("'?''\\''\"\\\"\"\"\"?", 1'b1);
    drain();
  endtask

  task automatic test_comments();
    send_text("-?/?--?\n//?\n/*?**/?", 1'b1);
    drain();
  endtask

  task automatic test_random_statements();
    int sent;
    int len;
    int r;
    sent = 0;
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      // first stretch runs with no gaps on either side
      if (sent >= 300) begin
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 5) begin
        push_char(8'($urandom), 1'($urandom), 1'b1);
        sent++;
      end else begin
        len = (r < 90) ? $urandom_range(1, 24) : $urandom_range(25, 80);
        for (int i = 0; i < len; i++) begin
          if (i > 0 && $urandom_range(99) == 0) begin
            push_char(8'($urandom), 1'($urandom), 1'b1);
            sent++;
            break;
          end
          push_char(pick_char(), i == len - 1, 1'b0);
          sent++;
        end
      end
    end
    drain();
  endtask

  // receiver holds off while one-byte statements keep coming
  task automatic test_output_hold();
    send_gaps = 1'b0;
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 40; i++)
      push_char((i % 2) ? smc_pkg::CH_QMARK : 8'($urandom), 1'b1, 1'b0);
    drain();
    send_gaps = 1'b1;
  endtask

  // receiver: random stalls, plus a counted hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= recv_gaps && ($urandom_range(99) < 30);
      end
    end
  end

  // result checker
  initial begin
    stmt_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no statement pending", int'(marker_count), -1);
        end else begin
          want = pending_results.pop_front();
          if (marker_count !== want.count)
            report_mismatch("marker_count", int'(marker_count), int'(want.count));
          if (was_empty !== want.empty)
            report_mismatch("was_empty", int'(was_empty), int'(want.empty));
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either channel
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    scan_mode    = smc_pkg::MODE_NORMAL;
    marker_tally = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_statement_ends();
    test_quotes();
    test_comments();
    test_random_statements();
    test_output_hold();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
